// ===== rtl/b58_pkg.sv =====
// Shared constants, types and the alphabet decoder of the base58 string decoder.
package b58_pkg;

  localparam int unsigned AccWordsDef = 16;
  localparam int unsigned MaxCharsDef = 64;
  localparam int unsigned MaxOut      = 60;
  localparam int unsigned Radix       = 58;
  localparam int unsigned CntW        = 7;
  localparam logic [31:0] TrackInit   = 32'd57;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } digit_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_FIN  = 6'b000100,
    S_SIZE = 6'b001000,
    S_EMIT = 6'b010000,
    S_ERR  = 6'b100000
  } state_e;

  // Maps an ASCII code to its base58 digit; ok is low for codes outside the alphabet.
  function automatic digit_t b58_digit(input logic [7:0] code);
    digit_t     d;
    logic [7:0] v;
    v    = '0;
    d.ok = 1'b1;
    case (code) inside
      [8'd49:8'd57]:   v = code - 8'd49;
      [8'd65:8'd72]:   v = code - 8'd56;
      [8'd74:8'd78]:   v = code - 8'd57;
      [8'd80:8'd90]:   v = code - 8'd58;
      [8'd97:8'd107]:  v = code - 8'd64;
      [8'd109:8'd122]: v = code - 8'd65;
      default:         d.ok = 1'b0;
    endcase
    d.val = v[5:0];
    return d;
  endfunction

endpackage

// ===== rtl/b58_if.sv =====
// Valid/ready channel interfaces for characters in and decoded bytes out.
interface b58_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       in_last;

  modport source (output valid, output char_code, output in_last, input ready);
  modport sink (input valid, input char_code, input in_last, output ready);
endinterface

interface b58_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       out_last;
  logic       bad_input;

  modport source (output valid, output data_byte, output out_last, output bad_input,
                  input ready);
  modport sink (input valid, input data_byte, input out_last, input bad_input,
                output ready);
endinterface

// ===== rtl/b58_mac.sv =====
// Word step of the multiply-by-58 unit: {carry, word} = word * 58 + carry.
module b58_mac
  import b58_pkg::*;
(
  input  logic [31:0] word_i,
  input  logic [5:0]  carry_i,
  output logic [31:0] word_o,
  output logic [5:0]  carry_o
);

  logic [37:0] prod;

  // The carry stays below 58, so 38 bits hold the full result.
  assign prod    = 38'(word_i) * 38'(Radix) + 38'(carry_i);
  assign word_o  = prod[31:0];
  assign carry_o = prod[37:32];

endmodule

// ===== rtl/b58_bytecnt.sv =====
// Byte count of the decoded result from the length tracker's top word.
module b58_bytecnt
  import b58_pkg::*;
#(
  parameter int unsigned ACC_WORDS = AccWordsDef
) (
  input  logic [31:0]                    top_word_i,
  input  logic [$clog2(ACC_WORDS)-1:0]   top_idx_i,
  output logic [CntW-1:0]                count_o
);

  logic [CntW-1:0] base;
  logic [CntW-1:0] adj;
  logic [CntW-1:0] raw;

  assign base = CntW'({top_idx_i, 2'b00}) + CntW'(4);

  always_comb begin
    if (top_word_i[31:24] != '0) begin
      adj = CntW'(0);
    end else if (top_word_i[23:16] != '0) begin
      adj = CntW'(1);
    end else if (top_word_i[15:8] != '0) begin
      adj = CntW'(2);
    end else begin
      adj = CntW'(3);
    end
  end

  assign raw     = base - adj;
  assign count_o = (raw > CntW'(MaxOut)) ? CntW'(MaxOut) : raw;

endmodule

// ===== rtl/base58_string_decoder.sv =====
// Base58 string decoder: characters in, big-endian decoded bytes out.
//
// Characters arrive one per request, the final one flagged by in_last. A valid character
// that is processed passes through S_MUL: the accumulator and the length tracker (from
// the second character on) are multiplied by 58 one 32-bit word per cycle through the two
// word multiply units. A character skipped after an error, or one that raises the error,
// bypasses S_MUL. After the final character, S_SIZE sizes the result, then the decoded bytes
// leave at one per cycle while the sink is ready; a bad string gives a single request with
// bad_input set. No new character is taken until the last byte of a result has gone.
module base58_string_decoder
  import b58_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MaxCharsDef,
  parameter int unsigned ACC_WORDS = AccWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b58_in_if.sink      in_i,
  b58_out_if.source   out_o
);

  localparam int unsigned WW  = $clog2(ACC_WORDS);
  localparam int unsigned UW  = $clog2(ACC_WORDS + 1);
  localparam int unsigned CSW = $clog2(MAX_CHARS + 1);

  state_e           state_q, state_d;
  logic [31:0]      value_q [ACC_WORDS];
  logic [31:0]      track_q [ACC_WORDS];
  logic [UW-1:0]    wiu_q, wiu_d;
  logic [CSW-1:0]   chars_q, chars_d;
  logic             err_q, err_d;
  logic             last_q, last_d;
  logic [WW-1:0]    w_q, w_d;
  logic [5:0]       cv_q, cv_d;
  logic [5:0]       ct_q, ct_d;
  logic [CntW-2:0]  i_q, i_d;
  logic             clear;

  logic             in_acc;
  logic             out_acc;
  digit_t           dig;
  logic             track_en;
  logic [31:0]      mv_word, mt_word;
  logic [5:0]       mv_carry, mt_carry;
  logic [CntW-1:0]  n_bytes;
  logic [31:0]      out_word;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign dig      = b58_digit(in_i.char_code);
  assign track_en = (chars_q != '0);

  b58_mac u_mac_value (
    .word_i  (value_q[w_q]),
    .carry_i (cv_q),
    .word_o  (mv_word),
    .carry_o (mv_carry)
  );

  b58_mac u_mac_track (
    .word_i  (track_q[w_q]),
    .carry_i (ct_q),
    .word_o  (mt_word),
    .carry_o (mt_carry)
  );

  b58_bytecnt #(
    .ACC_WORDS (ACC_WORDS)
  ) u_bytecnt (
    .top_word_i (track_q[WW'(wiu_q - UW'(1))]),
    .top_idx_i  (WW'(wiu_q - UW'(1))),
    .count_o    (n_bytes)
  );

  always_comb begin
    state_d = state_q;
    wiu_d   = wiu_q;
    chars_d = chars_q;
    err_d   = err_q;
    last_d  = last_q;
    w_d     = w_q;
    cv_d    = cv_q;
    ct_d    = ct_q;
    i_d     = i_q;
    clear   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          last_d  = in_i.in_last;
          state_d = S_FIN;
          if (!err_q) begin
            if (chars_q == CSW'(MAX_CHARS) || !dig.ok) begin
              err_d = 1'b1;
            end else begin
              cv_d    = dig.val;
              ct_d    = '0;
              w_d     = '0;
              state_d = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        cv_d = mv_carry;
        if (track_en) begin
          ct_d = mt_carry;
          // A carry landing on the first unused tracker word brings it into use.
          if (UW'(w_q) == wiu_q && ct_q != '0) begin
            wiu_d = wiu_q + UW'(1);
          end
        end
        if (w_q == WW'(ACC_WORDS - 1)) begin
          chars_d = chars_q + CSW'(1);
          state_d = S_FIN;
        end else begin
          w_d = w_q + WW'(1);
        end
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (err_q) begin
          state_d = S_ERR;
        end else begin
          state_d = S_SIZE;
        end
      end
      S_SIZE: begin
        i_d     = (CntW-1)'(n_bytes - CntW'(1));
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (i_q == '0) begin
            clear   = 1'b1;
            state_d = S_IDLE;
          end else begin
            i_d = i_q - (CntW-1)'(1);
          end
        end
      end
      S_ERR: begin
        if (out_acc) begin
          clear   = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (clear) begin
      wiu_d   = UW'(1);
      chars_d = '0;
      err_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wiu_q   <= UW'(1);
      chars_q <= '0;
      err_q   <= 1'b0;
      last_q  <= 1'b0;
      w_q     <= '0;
      cv_q    <= '0;
      ct_q    <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      wiu_q   <= wiu_d;
      chars_q <= chars_d;
      err_q   <= err_d;
      last_q  <= last_d;
      w_q     <= w_d;
      cv_q    <= cv_d;
      ct_q    <= ct_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ACC_WORDS; k++) begin
        value_q[k] <= '0;
        track_q[k] <= (k == 0) ? TrackInit : '0;
      end
    end else if (clear) begin
      for (int k = 0; k < ACC_WORDS; k++) begin
        value_q[k] <= '0;
        track_q[k] <= (k == 0) ? TrackInit : '0;
      end
    end else if (state_q == S_MUL) begin
      value_q[w_q] <= mv_word;
      if (track_en) begin
        track_q[w_q] <= mt_word;
      end
    end
  end

  assign out_word = value_q[WW'(i_q >> 2)];

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = (state_q == S_EMIT) || (state_q == S_ERR);
  assign out_o.data_byte = (state_q == S_EMIT) ? out_word[8*i_q[1:0] +: 8] : '0;
  assign out_o.out_last  = (state_q == S_ERR) || (i_q == '0);
  assign out_o.bad_input = (state_q == S_ERR);

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("ready did not drop after a character request");

  a_wiu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wiu_q != '0) && (wiu_q <= UW'(ACC_WORDS)))
    else $error("tracker word count out of range");

  a_chars_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= CSW'(MAX_CHARS))
    else $error("character count beyond limit");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_o.bad_input |=> in_i.ready && !err_q && (chars_q == '0))
    else $error("state not cleared after error result");
`endif

endmodule

// ===== test/b58_checker.sv =====
// Watches both channels of the base58 decoder, predicts the decoded bytes and compares them.
module b58_checker
  import b58_pkg::*;
#(
  parameter int unsigned          MAX_CHARS = MaxCharsDef,
  parameter int unsigned          ACC_WORDS = AccWordsDef,
  parameter logic [8*Radix-1:0]   ALPHABET  = '0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b58_in_if           in_ch,
  b58_out_if          out_ch,
  output int unsigned errors_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AccBits = 32 * ACC_WORDS;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       out_last;
    logic       bad_input;
  } dec_byte_t;

  dec_byte_t          decoded_q[$];
  logic [AccBits-1:0] acc_value;
  logic [AccBits-1:0] len_track;
  int unsigned        char_cnt;
  logic               str_err;

  function automatic int digit_of(input logic [7:0] code);
    for (int k = 0; k < Radix; k++) begin
      if (ALPHABET[8*(Radix-1-k) +: 8] == code) return k;
    end
    return -1;
  endfunction

  function automatic void clear_string();
    acc_value = '0;
    len_track = AccBits'(TrackInit);
    char_cnt  = 0;
    str_err   = 1'b0;
  endfunction

  // Updates the running value for one character; the last one queues the decoded bytes.
  function automatic void decode_char(input logic [7:0] code, input logic last);
    int          digit;
    int unsigned nbytes;
    int          k;
    dec_byte_t   r;
    digit = digit_of(code);
    if (!str_err) begin
      if (char_cnt >= MAX_CHARS || digit < 0) begin
        str_err = 1'b1;
      end else begin
        if (char_cnt > 0) len_track = len_track * Radix;
        acc_value = acc_value * Radix + 6'(digit);
        char_cnt++;
      end
    end
    if (last) begin
      if (str_err) begin
        r = '{data_byte: 8'h00, out_last: 1'b1, bad_input: 1'b1};
        decoded_q.push_back(r);
      end else begin
        // The result is as long as the length tracker, counted in whole bytes.
        nbytes = 1;
        for (k = 0; k < AccBits / 8; k++) begin
          if (len_track[8*k +: 8] != 8'h00) nbytes = k + 1;
        end
        if (nbytes > MaxOut) nbytes = MaxOut;
        for (k = int'(nbytes) - 1; k >= 0; k--) begin
          r = '{data_byte: acc_value[8*k +: 8], out_last: (k == 0), bad_input: 1'b0};
          decoded_q.push_back(r);
        end
      end
      clear_string();
    end
  endfunction

  function automatic void check_byte(input dec_byte_t got);
    dec_byte_t want;
    if (decoded_q.size() == 0) begin
      if (errors_o < 10)
        $display("%0t: unexpected byte: data %02h last %0b bad %0b", $time,
                 got.data_byte, got.out_last, got.bad_input);
      errors_o++;
    end else begin
      want = decoded_q.pop_front();
      if (want.data_byte != got.data_byte || want.out_last != got.out_last ||
          want.bad_input != got.bad_input) begin
        if (errors_o < 10)
          $display("%0t: byte mismatch: expected data %02h last %0b bad %0b, got data %02h last %0b bad %0b",
                   $time, want.data_byte, want.out_last, want.bad_input,
                   got.data_byte, got.out_last, got.bad_input);
        errors_o++;
      end
    end
  endfunction

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_string();
      decoded_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready)
        check_byte('{data_byte: out_ch.data_byte, out_last: out_ch.out_last,
                     bad_input: out_ch.bad_input});
      if (in_ch.valid && in_ch.ready) decode_char(in_ch.char_code, in_ch.in_last);
    end
    pending_o = decoded_q.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the base58 decoder testbench: clock, reset, character stimulus and verdict.
module tb
  import b58_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*Radix-1:0] B58Alphabet =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandItems  = 380;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 77;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;
  int unsigned rand_items = 0;
  logic [7:0]  str_q[$];

  b58_in_if  in_ch ();
  b58_out_if out_ch ();

  base58_string_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  b58_checker #(
    .ALPHABET (B58Alphabet)
  ) i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors_o  (fail_cnt),
    .pending_o (pending_cnt)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Byte receiver; a requested hold keeps ready low for a long stretch.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_reqs != holds_done) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] code, input logic last);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= code;
    in_ch.in_last   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Sends the buffered string; a hold may be requested just before its last character.
  task automatic send_string(input logic hold_on_last);
    for (int i = 0; i < str_q.size(); i++) begin
      if (hold_on_last && i == str_q.size() - 1) hold_reqs++;
      send_char(str_q[i], i == str_q.size() - 1);
    end
  endtask

  initial begin
    int unsigned str_cnt;
    int unsigned long_cnt;
    int unsigned len;
    logic        noisy;
    logic [7:0]  code;
    str_cnt  = 0;
    long_cnt = 0;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = 8'h00;
    in_ch.in_last   = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero digit, top digit, leading zeros, the edges of every alphabet range,
    // invalid codes alone and inside a string, and codes at both ends of the byte.
    str_q = '{"1"};
    send_string(1'b0);
    str_q = '{"z"};
    send_string(1'b0);
    str_q = '{"1", "1"};
    send_string(1'b0);
    str_q = '{"1", "9", "A", "H", "J", "N", "P", "Z", "a", "k", "m", "z"};
    send_string(1'b0);
    str_q = '{"0"};
    send_string(1'b0);
    str_q = '{"1", "I", "5"};
    send_string(1'b0);
    str_q = '{8'hFF};
    send_string(1'b0);
    str_q = '{8'h00};
    send_string(1'b0);

    // Mostly valid strings, every tenth one at or just past the length limit.
    while (rand_items < RandItems) begin
      if (rand_items >= 260) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (rand_items >= 130) begin
        send_idle_pct = 77;
        recv_idle_pct = 33;
      end
      if (str_cnt % 10 == 5) begin
        len = (long_cnt % 2 == 0) ? MaxCharsDef : MaxCharsDef + 1;
        long_cnt++;
      end else begin
        len = $urandom_range(1, 12);
      end
      str_q.delete();
      noisy = 1'b0;
      for (int i = 0; i < len; i++) begin
        if (long_cnt == 1 && len >= MaxCharsDef) begin
          code = "z";
        end else if ($urandom_range(99) < 4) begin
          code  = 8'($urandom_range(0, 255));
          noisy = 1'b1;
        end else begin
          code = B58Alphabet[8*$urandom_range(0, Radix - 1) +: 8];
        end
        str_q.push_back(code);
        if (!noisy) rand_items++;
      end
      send_string(str_cnt == 3);
      str_cnt++;
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
